// ----- src/k_closest_sorted_window_search_macros.svh -----
// Assertion macros for the window search RTL.
`ifndef K_CLOSEST_SORTED_WINDOW_SEARCH_MACROS_SVH
`define K_CLOSEST_SORTED_WINDOW_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define KCSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcsw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KCSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcsw assertion failed");

`else

`define KCSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KCSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/kcsw_pkg.sv -----
`default_nettype none

package kcsw_pkg;

  // Field widths of the channels and registers.
  localparam int OP_W      = 2;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 11;
  localparam int HW_W      = 4;
  localparam int RES_W     = 31;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 31;

  // Clamped half window, window size and distance limit widths.
  localparam int M_W   = 5;
  localparam int K_W   = 6;
  localparam int LIM_W = 37;

  // Command queue geometry.
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = 1;
  localparam int Q_CW    = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION  = 1'd1;

  // Register reset values.
  localparam logic [HW_W-1:0]  HW_RESET  = 4'd3;
  localparam logic [RES_W-1:0] RES_RESET = 31'd1;

  // A classified command on its way to the execution side.
  typedef struct packed {
    logic [OP_W-1:0]         kind;
    logic signed [VAL_W-1:0] value;
  } kcsw_cmd_t;

  // Derived configuration seen by the execution side.
  typedef struct packed {
    logic [M_W-1:0]   m;
    logic [LIM_W-1:0] limit;
  } kcsw_cfg_t;

endpackage

`default_nettype wire

// ----- src/kcsw_in_if.sv -----
`default_nettype none

interface kcsw_in_if;
  import kcsw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ----- src/kcsw_out_if.sv -----
`default_nettype none

interface kcsw_out_if;
  import kcsw_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic             valid_res;
  logic             last;

  modport source (output valid, output index, output valid_res, output last, input ready);
  modport sink (input valid, input index, input valid_res, input last, output ready);
endinterface

`default_nettype wire

// ----- src/kcsw_fifo.sv -----
`default_nettype none

module kcsw_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  kcsw_pkg::kcsw_cmd_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output kcsw_pkg::kcsw_cmd_t pop_data
);
  import kcsw_pkg::*;

  kcsw_cmd_t       ents_r [Q_DEPTH];
  logic [Q_PW-1:0] wp_r;
  logic [Q_PW-1:0] rp_r;
  logic [Q_CW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ents_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) ents_r[wp_r] <= push_data;
  end

endmodule

`default_nettype wire

// ----- src/kcsw_front.sv -----
`default_nettype none

module kcsw_front #(
  parameter int MAX_HALF = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  kcsw_in_if.sink                        in_ch,
  input  logic                           cfg_we,
  input  logic [kcsw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [kcsw_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output kcsw_pkg::kcsw_cmd_t            cmd,
  output kcsw_pkg::kcsw_cfg_t            cfg
);
  import kcsw_pkg::*;

  logic [HW_W-1:0]  hw_r;
  logic [RES_W-1:0] res_r;
  logic [M_W-1:0]   m_nxt;
  logic [K_W-1:0]   k_w;
  logic [LIM_W-1:0] lim_nxt;
  kcsw_cfg_t        cfg_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r  <= HW_RESET;
      res_r <= RES_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HALF_WINDOW: hw_r  <= cfg_wdata[HW_W-1:0];
        REG_RESOLUTION:  res_r <= cfg_wdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the half window and form the distance limit (2m+1) * resolution.
  always_comb begin
    m_nxt = M_W'(hw_r);
    if (m_nxt == '0) m_nxt = M_W'(1);
    else if (m_nxt > M_W'(MAX_HALF)) m_nxt = M_W'(MAX_HALF);
    k_w     = {m_nxt, 1'b1};
    lim_nxt = LIM_W'(k_w) * LIM_W'(res_r);
  end

  always_ff @(posedge clk) begin
    cfg_r.m     <= m_nxt;
    cfg_r.limit <= lim_nxt;
  end

  assign cfg = cfg_r;

  // Reserved operations are taken and dropped; all others enter the queue.
  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid && (in_ch.op != OP_RSVD);
  assign cmd.kind    = in_ch.op;
  assign cmd.value   = in_ch.value;

endmodule

`default_nettype wire

// ----- src/kcsw_back.sv -----
`default_nettype none
`include "k_closest_sorted_window_search_macros.svh"

module kcsw_back #(
  parameter int STORE_DEPTH = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  kcsw_pkg::kcsw_cmd_t cmd,
  input  kcsw_pkg::kcsw_cfg_t cfg,
  kcsw_out_if.source          out_ch
);
  import kcsw_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int SW = ((FW > K_W) ? FW : K_W) + 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BS    = 4'd1;
  localparam logic [3:0] ST_BSW   = 4'd2;
  localparam logic [3:0] ST_PLACE = 4'd3;
  localparam logic [3:0] ST_SLA   = 4'd4;
  localparam logic [3:0] ST_SLB   = 4'd5;
  localparam logic [3:0] ST_SLC   = 4'd6;
  localparam logic [3:0] ST_SRA   = 4'd7;
  localparam logic [3:0] ST_SRB   = 4'd8;
  localparam logic [3:0] ST_SRC   = 4'd9;
  localparam logic [3:0] ST_FA    = 4'd10;
  localparam logic [3:0] ST_FB    = 4'd11;
  localparam logic [3:0] ST_FIN   = 4'd12;

  logic [VAL_W-1:0]        mem [STORE_DEPTH];
  logic signed [VAL_W-1:0] rdata_r;
  logic [AW-1:0]           rd_addr;
  logic [FW-1:0]           rd_pos;

  logic [3:0]              state_r, state_nxt;
  logic [FW-1:0]           fill_r, fill_nxt;
  logic signed [VAL_W-1:0] q_r, q_nxt;
  logic [FW-1:0]           lo_r, lo_nxt, hi_r, hi_nxt;
  logic [FW-1:0]           left_r, left_nxt, right_r, right_nxt;
  logic [FW-1:0]           i_r, i_nxt, pend_r, pend_nxt;
  logic                    have_r, have_nxt, unf_r, unf_nxt;
  logic signed [VAL_W-1:0] a_r, a_nxt;

  logic [FW:0]             mid_sum;
  logic [FW-1:0]           mid;
  logic                    wr_en;

  // Window placement arithmetic.
  logic signed [SW-1:0]    lo_s, n_s, m_s, k_s, l_s, r_s, nk_s;

  // Slide and filter comparisons.
  logic signed [VAL_W:0]   qx, ax, dx;
  logic signed [VAL_W:0]   q_minus_a, d_minus_q, q_minus_d;
  logic [VAL_W:0]          ad;
  logic                    pass;

  // Result register.
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_index_r;
  logic                    out_vres_r, out_last_r;
  logic                    can_push, push_en, push_vres, push_last;
  logic [FW-1:0]           push_pos;
  logic [FW+IDX_W-1:0]     push_ext;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[FW:1];
  assign cmd_ready = (state_r == ST_IDLE);
  assign can_push  = !out_valid_r || out_ch.ready;

  // Read address follows the state so the read data holds across a stall.
  always_comb begin
    case (state_r)
      ST_BS, ST_BSW:  rd_pos = mid;
      ST_SLA:         rd_pos = left_r - 1'b1;
      ST_SLB, ST_SLC: rd_pos = right_r - 1'b1;
      ST_SRA:         rd_pos = right_r;
      ST_SRB, ST_SRC: rd_pos = left_r;
      default:        rd_pos = i_r;
    endcase
  end
  assign rd_addr = rd_pos[AW-1:0];

  // Timestamp store: one write and one registered read per cycle.
  assign wr_en = (state_r == ST_IDLE) && cmd_valid && (cmd.kind == OP_APPEND)
                 && (fill_r < FW'(STORE_DEPTH));
  always_ff @(posedge clk) begin
    if (wr_en) mem[fill_r[AW-1:0]] <= cmd.value;
    rdata_r <= mem[rd_addr];
  end

  // Window placement from the lower bound.
  always_comb begin
    lo_s = $signed(SW'(lo_r));
    n_s  = $signed(SW'(fill_r));
    m_s  = $signed(SW'(cfg.m));
    k_s  = $signed(SW'({cfg.m, 1'b1}));
    nk_s = n_s - k_s;
    if (nk_s < 0) nk_s = '0;
    l_s = lo_s - m_s;
    r_s = l_s + k_s;
    if (l_s < 0) begin
      l_s = '0;
      r_s = k_s;
    end
    if (r_s > n_s) begin
      r_s = n_s;
      l_s = nk_s;
    end
  end

  // Distances against the query.
  always_comb begin
    qx        = $signed({q_r[VAL_W-1], q_r});
    ax        = $signed({a_r[VAL_W-1], a_r});
    dx        = $signed({rdata_r[VAL_W-1], rdata_r});
    q_minus_a = qx - ax;
    d_minus_q = dx - qx;
    q_minus_d = qx - dx;
    ad        = d_minus_q[VAL_W] ? $unsigned(q_minus_d) : $unsigned(d_minus_q);
    pass      = unf_r || (LIM_W'({ad, 1'b0}) < cfg.limit);
  end

  // Query sequencer.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    q_nxt     = q_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    i_nxt     = i_r;
    pend_nxt  = pend_r;
    have_nxt  = have_r;
    unf_nxt   = unf_r;
    a_nxt     = a_r;
    push_en   = 1'b0;
    push_pos  = pend_r;
    push_vres = 1'b1;
    push_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            OP_APPEND: if (fill_r < FW'(STORE_DEPTH)) fill_nxt = fill_r + 1'b1;
            OP_CLEAR:  fill_nxt = '0;
            OP_QUERY: begin
              q_nxt     = cmd.value;
              lo_nxt    = '0;
              hi_nxt    = fill_r;
              have_nxt  = 1'b0;
              state_nxt = ST_BS;
            end
            default: ;
          endcase
        end
      end
      ST_BS: state_nxt = (lo_r < hi_r) ? ST_BSW : ST_PLACE;
      ST_BSW: begin
        if (rdata_r < q_r) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = ST_BS;
      end
      ST_PLACE: begin
        if (lo_r == '0) begin
          left_nxt  = '0;
          right_nxt = (k_s < n_s) ? k_s[FW-1:0] : fill_r;
          unf_nxt   = 1'b1;
          i_nxt     = '0;
          state_nxt = ST_FA;
        end else if (lo_r == fill_r) begin
          left_nxt  = nk_s[FW-1:0];
          right_nxt = fill_r;
          unf_nxt   = 1'b1;
          i_nxt     = nk_s[FW-1:0];
          state_nxt = ST_FA;
        end else begin
          left_nxt  = l_s[FW-1:0];
          right_nxt = r_s[FW-1:0];
          unf_nxt   = 1'b0;
          state_nxt = ST_SLA;
        end
      end
      ST_SLA: state_nxt = (left_r != '0) ? ST_SLB : ST_SRA;
      ST_SLB: begin
        a_nxt     = rdata_r;
        state_nxt = ST_SLC;
      end
      ST_SLC: begin
        if (q_minus_a <= d_minus_q) begin
          left_nxt  = left_r - 1'b1;
          right_nxt = right_r - 1'b1;
          state_nxt = ST_SLA;
        end else begin
          state_nxt = ST_SRA;
        end
      end
      ST_SRA: begin
        if (right_r < fill_r) begin
          state_nxt = ST_SRB;
        end else begin
          i_nxt     = left_r;
          state_nxt = ST_FA;
        end
      end
      ST_SRB: begin
        a_nxt     = rdata_r;
        state_nxt = ST_SRC;
      end
      ST_SRC: begin
        // Here a_r holds the entry at right and rdata_r the entry at left.
        if ((ax - qx) < q_minus_d) begin
          left_nxt  = left_r + 1'b1;
          right_nxt = right_r + 1'b1;
          state_nxt = ST_SRA;
        end else begin
          i_nxt     = left_r;
          state_nxt = ST_FA;
        end
      end
      ST_FA: state_nxt = (i_r < right_r) ? ST_FB : ST_FIN;
      ST_FB: begin
        // A passing index is held back until the next one shows it is not last.
        if (!pass) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_FA;
        end else if (!have_r || can_push) begin
          push_en   = have_r;
          pend_nxt  = i_r;
          have_nxt  = 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_FA;
        end
      end
      ST_FIN: begin
        if (can_push) begin
          push_en   = 1'b1;
          push_last = 1'b1;
          push_vres = have_r;
          push_pos  = have_r ? pend_r : '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    i_r     <= i_nxt;
    pend_r  <= pend_nxt;
    unf_r   <= unf_nxt;
    a_r     <= a_nxt;
  end

  // Output register decouples the sequencer from the result sink.
  assign push_ext = (FW + IDX_W)'(push_pos);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      out_index_r <= push_ext[IDX_W-1:0];
      out_vres_r  <= push_vres;
      out_last_r  <= push_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.index     = out_index_r;
  assign out_ch.valid_res = out_vres_r;
  assign out_ch.last      = out_last_r;

  // Checks on the sequencer.
  `KCSW_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FW'(STORE_DEPTH))
  `KCSW_ASSERT_IMP(a_bs_order, clk, rst_n, (state_r == ST_BS) || (state_r == ST_BSW),
                   lo_r <= hi_r)
  `KCSW_ASSERT_IMP(a_filter_span, clk, rst_n, state_r == ST_FA,
                   (i_r >= left_r) && (i_r <= right_r) && (right_r <= fill_r))
  `KCSW_ASSERT_NXT(a_fin_last, clk, rst_n, (state_r == ST_FIN) && can_push,
                   out_valid_r && out_last_r && (state_r == ST_IDLE))

endmodule

`default_nettype wire

// ----- src/k_closest_sorted_window_search.sv -----
`default_nettype none
// Channel   Dir  Payload                     Handshake
// in_ch     in   op, value                   valid/ready
// out_ch    out  index, valid_res, last      valid/ready
// cfg       in   cfg_idx, cfg_wdata          cfg_we
//
// Appends and clears are done in the idle state of the execution side;
// reserved ops are dropped by the front side. A query runs a binary search
// (at most ceil(log2(fill+1)) steps), places the window, slides it toward
// the query and filters the window entries; every store read goes through
// the one registered read port. Reset is synchronous and empties the store;
// stalls on out_ch hold the sequencer, while a two-entry command queue
// keeps taking items until it is full.

module k_closest_sorted_window_search #(
  parameter int STORE_DEPTH = 2048,
  parameter int MAX_HALF    = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  kcsw_in_if.sink                        in_ch,
  kcsw_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [kcsw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [kcsw_pkg::CFG_W-1:0]     cfg_wdata
);
  import kcsw_pkg::*;

  kcsw_cmd_t f_cmd, q_cmd;
  kcsw_cfg_t cfg;
  logic      f_valid, f_ready, q_valid, q_ready;

  kcsw_front #(.MAX_HALF(MAX_HALF)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd),
    .cfg       (cfg)
  );

  kcsw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  kcsw_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
